[hw/rtl/uint128_literal_parser_top_macros.svh]
// Assertion helpers used by the checker.
`ifndef UINT128_LITERAL_PARSER_TOP_MACROS_SVH
`define UINT128_LITERAL_PARSER_TOP_MACROS_SVH

// Clocked assertion, masked while reset is active.
`define ULP_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ULP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[hw/rtl/ulp_pkg.sv]
`default_nettype none

package ulp_pkg;

  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_ZERO   = 2'd1,
    PH_DIGITS = 2'd2,
    PH_FIXED  = 2'd3
  } ulp_phase_e;

  typedef enum logic [1:0] {
    BASE_DEC = 2'd0,
    BASE_HEX = 2'd1,
    BASE_OCT = 2'd2,
    BASE_BIN = 2'd3
  } ulp_base_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_OVERFLOW = 2'd2
  } ulp_status_e;

  localparam int unsigned ValueW = 128;
  localparam int unsigned CountW = 8;

  // Significant digit limits per base
  localparam logic [CountW-1:0] LIMIT_DEC = 8'd39;
  localparam logic [CountW-1:0] LIMIT_HEX = 8'd32;
  localparam logic [CountW-1:0] LIMIT_OCT = 8'd43;
  localparam logic [CountW-1:0] LIMIT_BIN = 8'd128;

  // (2^128 - 1) / 10, remainder 5
  localparam logic [ValueW-1:0] DEC_QUOT = 128'h1999999999999999_9999999999999999;
  localparam logic [3:0]        DEC_REM  = 4'd5;

  // ASCII codes
  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_1  = 8'h31;
  localparam logic [7:0] CH_7  = 8'h37;
  localparam logic [7:0] CH_9  = 8'h39;
  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_UF = 8'h46;
  localparam logic [7:0] CH_UX = 8'h58;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LB = 8'h62;
  localparam logic [7:0] CH_LF = 8'h66;
  localparam logic [7:0] CH_LO = 8'h6f;
  localparam logic [7:0] CH_LX = 8'h78;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
  } ulp_item_t;

  typedef struct packed {
    ulp_phase_e         phase;
    ulp_base_e          base;
    logic [ValueW-1:0]  acc;
    logic [CountW-1:0]  count;
    ulp_status_e        status;
  } ulp_state_t;

  typedef struct packed {
    logic [ValueW-1:0] value;
    ulp_status_e       status;
  } ulp_result_t;

  localparam ulp_state_t STATE_RESET = '{
    phase:  PH_START,
    base:   BASE_DEC,
    acc:    '0,
    count:  '0,
    status: ST_OK
  };

endpackage

`default_nettype wire

[hw/rtl/ulp_in_stage.sv]
`default_nettype none

module ulp_in_stage
  import ulp_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire ulp_item_t item_i,
  input  wire logic      advance_i,
  output logic           valid_o,
  output ulp_item_t      item_o
);

  logic      valid_q;
  ulp_item_t item_q;
  logic      load;

  // The register refills when it is empty or its content moves on in the same cycle.
  assign load       = !valid_q || advance_i;
  assign in_stall_o = !load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && in_valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

[hw/rtl/ulp_step.sv]
`default_nettype none

module ulp_step
  import ulp_pkg::*;
(
  input  wire ulp_state_t state_i,
  input  wire ulp_item_t  item_i,
  output ulp_state_t      state_o,
  output ulp_result_t     result_o
);

  logic [7:0]        ch;
  ulp_state_t        nxt;
  logic              take;
  logic              dig_ok;
  logic [3:0]        dig;
  logic [CountW-1:0] limit;
  logic [ValueW-1:0] mul10;
  logic              dec_ovf;

  assign ch = item_i.char_code;

  always_comb begin
    nxt  = state_i;
    take = 1'b0;
    unique case (state_i.phase)
      PH_START: begin
        if (ch == CH_0 && !item_i.is_last) begin
          nxt.phase = PH_ZERO;
        end else begin
          nxt.phase = PH_DIGITS;
          nxt.base  = BASE_DEC;
          take      = 1'b1;
        end
      end
      PH_ZERO: begin
        nxt.phase = PH_DIGITS;
        if (!item_i.is_last && (ch == CH_LX || ch == CH_UX || ch == CH_LO || ch == CH_LB)) begin
          nxt.base = (ch == CH_LO) ? BASE_OCT : (ch == CH_LB) ? BASE_BIN : BASE_HEX;
        end else begin
          nxt.base = BASE_DEC;
          take     = 1'b1;
        end
      end
      PH_DIGITS: take = 1'b1;
      PH_FIXED:  take = 1'b0;
      default:   take = 1'b0;
    endcase

    // digit decode for the base in effect
    dig_ok = 1'b0;
    dig    = '0;
    case (nxt.base)
      BASE_HEX: begin
        if (ch >= CH_LA && ch <= CH_LF) begin
          dig_ok = 1'b1;
          dig    = 4'(ch - CH_LA) + 4'd10;
        end else if (ch >= CH_UA && ch <= CH_UF) begin
          dig_ok = 1'b1;
          dig    = 4'(ch - CH_UA) + 4'd10;
        end else if (ch >= CH_0 && ch <= CH_9) begin
          dig_ok = 1'b1;
          dig    = 4'(ch - CH_0);
        end
      end
      BASE_OCT: begin
        dig_ok = (ch >= CH_0 && ch <= CH_7);
        dig    = 4'(ch - CH_0);
      end
      BASE_BIN: begin
        dig_ok = (ch == CH_0 || ch == CH_1);
        dig    = 4'(ch - CH_0);
      end
      default: begin
        dig_ok = (ch >= CH_0 && ch <= CH_9);
        dig    = 4'(ch - CH_0);
      end
    endcase

    case (nxt.base)
      BASE_HEX: limit = LIMIT_HEX;
      BASE_OCT: limit = LIMIT_OCT;
      BASE_BIN: limit = LIMIT_BIN;
      default:  limit = LIMIT_DEC;
    endcase

    // acc * 10 + d as acc * 8 + acc * 2 + d
    mul10   = {state_i.acc[ValueW-4:0], 3'b000} + {state_i.acc[ValueW-2:0], 1'b0}
            + ValueW'(dig);
    dec_ovf = (state_i.acc > DEC_QUOT) || (state_i.acc == DEC_QUOT && dig > DEC_REM);

    if (take && !(state_i.count == '0 && ch == CH_0)) begin
      if (state_i.count >= limit) begin
        nxt.acc    = '1;
        nxt.status = ST_OVERFLOW;
        nxt.phase  = PH_FIXED;
      end else if (!dig_ok) begin
        nxt.acc    = '0;
        nxt.status = ST_INVALID;
        nxt.phase  = PH_FIXED;
      end else if ((nxt.base == BASE_OCT && state_i.acc[ValueW-1 -: 3] != 3'b000) ||
                   (nxt.base == BASE_DEC && dec_ovf)) begin
        nxt.acc    = '1;
        nxt.status = ST_OVERFLOW;
        nxt.phase  = PH_FIXED;
      end else begin
        case (nxt.base)
          BASE_HEX: nxt.acc = {state_i.acc[ValueW-5:0], dig};
          BASE_OCT: nxt.acc = {state_i.acc[ValueW-4:0], dig[2:0]};
          BASE_BIN: nxt.acc = {state_i.acc[ValueW-2:0], dig[0]};
          default:  nxt.acc = mul10;
        endcase
        nxt.count = state_i.count + 1'b1;
      end
    end

    result_o.value  = nxt.acc;
    result_o.status = nxt.status;
    state_o         = item_i.is_last ? STATE_RESET : nxt;
  end

endmodule

`default_nettype wire

[hw/rtl/ulp_out_stage.sv]
`default_nettype none

module ulp_out_stage
  import ulp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        load_i,
  input  wire ulp_result_t result_i,
  output logic             free_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output ulp_result_t      result_o
);

  logic        valid_q;
  ulp_result_t result_q;

  assign free_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

`default_nettype wire

[hw/rtl/uint128_literal_parser_top.sv]
// Streaming parser for an unsigned 128-bit literal, one ASCII byte per transfer.
// Input channel: in_valid_i / in_stall_o with char_code_i and is_last_i; is_last_i
// marks the final byte. A "0x"/"0X", "0o" or "0b" prefix selects hex, octal or
// binary, otherwise the literal is decimal.
// Output channel: out_valid_o / out_stall_i with value_high_o, value_low_o and
// parse_status_o (0 ok, 1 invalid character, 2 overflow). One result per literal.
// Throughput: one byte per cycle unless a last byte waits for the output register;
// the accumulator update (shift, or times ten plus digit with a 128-bit compare) is
// combinational. Path: a byte is held in the input register; when a last byte moves
// on, its result is loaded into the output register, which drives out_valid_o.
// Stall: non-last bytes keep flowing while a result waits. A last byte waits in
// the input register until the output register frees, and in_stall_o rises.
// Reset: pipeline empty, parser back at the start of a new literal.

`default_nettype none

module uint128_literal_parser_top
  import ulp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  char_code_i,
  input  wire logic        is_last_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      value_high_o,
  output logic [63:0]      value_low_o,
  output logic [1:0]       parse_status_o
);

  ulp_item_t   in_item;
  ulp_item_t   s1_item;
  logic        s1_valid;
  logic        advance;
  logic        out_free;
  ulp_state_t  state_q;
  ulp_state_t  state_d;
  ulp_result_t step_res;
  ulp_result_t out_res;

  assign in_item.char_code = char_code_i;
  assign in_item.is_last   = is_last_i;

  ulp_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .advance_i  (advance),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  ulp_step u_step (
    .state_i  (state_q),
    .item_i   (s1_item),
    .state_o  (state_d),
    .result_o (step_res)
  );

  // a last byte only moves when its result has a place to go
  assign advance = s1_valid && (!s1_item.is_last || out_free);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_RESET;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  ulp_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && s1_item.is_last),
    .result_i    (step_res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_res)
  );

  assign value_high_o   = out_res.value[ValueW-1:ValueW/2];
  assign value_low_o    = out_res.value[ValueW/2-1:0];
  assign parse_status_o = out_res.status;

endmodule

`default_nettype wire

[hw/rtl/ulp_checker.sv]
`default_nettype none

`include "uint128_literal_parser_top_macros.svh"

module ulp_checker
  import ulp_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic [7:0]  char_code_i,
  input wire logic        is_last_i,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [63:0] value_high_o,
  input wire logic [63:0] value_low_o,
  input wire logic [1:0]  parse_status_o
);

  // the flop may still be unknown at the very first edge of reset
  `ULP_ASSERT_ALWAYS(a_no_result_in_reset, !rst_ni |=> !out_valid_o, "result valid during reset")

  `ULP_ASSERT_RST(a_in_hold, in_valid_i && in_stall_o |=> in_valid_i && $stable(char_code_i) && $stable(is_last_i), "stalled input changed")

  `ULP_ASSERT_RST(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(value_high_o) && $stable(value_low_o) && $stable(parse_status_o), "stalled result changed")

  `ULP_ASSERT_RST(a_status_code, out_valid_o |-> (parse_status_o == ST_OK || parse_status_o == ST_INVALID || parse_status_o == ST_OVERFLOW), "undefined status code")

  `ULP_ASSERT_RST(a_fill_value, out_valid_o && parse_status_o != ST_OK |-> ((parse_status_o == ST_OVERFLOW && value_high_o == '1 && value_low_o == '1) || (parse_status_o == ST_INVALID && value_high_o == '0 && value_low_o == '0)), "error status with wrong fill value")

endmodule

bind uint128_literal_parser_top ulp_checker u_ulp_checker (.*);

`default_nettype wire

[test/uint128_literal_parser_top_test.sv]
module uint128_literal_parser_top_test;
  import ulp_pkg::*;

  localparam logic [127:0] AllOnes = '1;
  localparam int NumRows = 31;
  localparam int RandomItems = 1000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic [7:0]  char_code_i = 8'd0;
  logic        is_last_i = 1'b0;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [63:0] value_high_o;
  logic [63:0] value_low_o;
  logic [1:0]  parse_status_o;

  uint128_literal_parser_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .char_code_i    (char_code_i),
    .is_last_i      (is_last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .value_high_o   (value_high_o),
    .value_low_o    (value_low_o),
    .parse_status_o (parse_status_o)
  );

  always #5 clk_i = ~clk_i;

  // literal = lead, then fill repeated fill_n times, then tail
  typedef struct {
    string        lead;
    byte unsigned fill;
    int           fill_n;
    string        tail;
    bit           typed;
    logic [127:0] value;
    ulp_status_e  status;
  } lit_row_t;

  lit_row_t lit_table [NumRows] = '{
    '{"0", 8'h00, 0, "", 1'b1, 128'd0, ST_OK},
    '{"9", 8'h00, 0, "", 1'b1, 128'd9, ST_OK},
    '{"000", 8'h00, 0, "", 1'b1, 128'd0, ST_OK},
    '{"0x000", 8'h00, 0, "", 1'b1, 128'd0, ST_OK},
    '{"18446744073709551616", 8'h00, 0, "", 1'b1, 128'h1_0000_0000_0000_0000, ST_OK},
    '{"340282366920938463463374607431768211455", 8'h00, 0, "", 1'b1, AllOnes, ST_OK},
    '{"340282366920938463463374607431768211456", 8'h00, 0, "", 1'b1, AllOnes, ST_OVERFLOW},
    '{"1", "0", 39, "z", 1'b1, AllOnes, ST_OVERFLOW},
    '{"000", "9", 39, "", 1'b0, 128'd0, ST_OK},
    '{"0x", "f", 32, "", 1'b1, AllOnes, ST_OK},
    '{"0x1", "0", 32, "", 1'b1, AllOnes, ST_OVERFLOW},
    '{"0XaBcDeF", 8'h00, 0, "", 1'b1, 128'habcdef, ST_OK},
    '{"0x1g", 8'h00, 0, "", 1'b1, 128'd0, ST_INVALID},
    '{"0x/", 8'h00, 0, "", 1'b0, 128'd0, ST_OK},
    '{"0o3", "7", 42, "", 1'b1, AllOnes, ST_OK},
    '{"0o4", "0", 42, "", 1'b1, AllOnes, ST_OVERFLOW},
    '{"0o17", 8'h00, 0, "", 1'b0, 128'd0, ST_OK},
    '{"0o8", 8'h00, 0, "", 1'b1, 128'd0, ST_INVALID},
    '{"0b", "1", 128, "", 1'b1, AllOnes, ST_OK},
    '{"0b1", "0", 128, "", 1'b1, AllOnes, ST_OVERFLOW},
    '{"0b12", 8'h00, 0, "", 1'b1, 128'd0, ST_INVALID},
    '{"0x", 8'h00, 0, "", 1'b1, 128'd0, ST_INVALID},
    '{"0O7", 8'h00, 0, "", 1'b1, 128'd0, ST_INVALID},
    '{"0B1", 8'h00, 0, "", 1'b1, 128'd0, ST_INVALID},
    '{"12a34", 8'h00, 0, "", 1'b1, 128'd0, ST_INVALID},
    '{"", 8'h01, 1, "", 1'b1, 128'd0, ST_INVALID},
    '{"", 8'hff, 1, "", 1'b1, 128'd0, ST_INVALID},
    '{"00x5", 8'h00, 0, "", 1'b0, 128'd0, ST_OK},
    '{"9:", 8'h00, 0, "", 1'b0, 128'd0, ST_OK},
    '{"0b", 8'h00, 0, "", 1'b0, 128'd0, ST_OK},
    '{"0o", 8'h00, 0, "", 1'b0, 128'd0, ST_OK}
  };

  int idle_pcts [4] = '{0, 70, 0, 33};
  int stall_pcts [4] = '{0, 0, 70, 33};

  int send_idle_pct = 0;
  int stall_pct = 0;
  int fail_count = 0;
  int items_sent = 0;

  ulp_result_t  parses_due [$];
  byte unsigned lit_chars [$];

  // Parser state mirror
  ulp_phase_e   lit_phase = PH_START;
  ulp_base_e    lit_base = BASE_DEC;
  logic [127:0] lit_acc = '0;
  int unsigned  lit_digits = 0;
  ulp_status_e  lit_status = ST_OK;

  function automatic void clear_literal();
    lit_phase = PH_START;
    lit_base = BASE_DEC;
    lit_acc = '0;
    lit_digits = 0;
    lit_status = ST_OK;
  endfunction

  function automatic void settle(ulp_status_e s);
    lit_acc = (s == ST_OVERFLOW) ? AllOnes : '0;
    lit_status = s;
    lit_phase = PH_FIXED;
  endfunction

  function automatic int digit_of(byte unsigned c, ulp_base_e b);
    case (b)
      BASE_HEX: begin
        if (c >= "0" && c <= "9") return c - "0";
        if (c >= "a" && c <= "f") return c - "a" + 10;
        if (c >= "A" && c <= "F") return c - "A" + 10;
        return -1;
      end
      BASE_OCT: return (c >= "0" && c <= "7") ? c - "0" : -1;
      BASE_BIN: return (c == "0" || c == "1") ? c - "0" : -1;
      default:  return (c >= "0" && c <= "9") ? c - "0" : -1;
    endcase
  endfunction

  function automatic void push_digit(byte unsigned c);
    int dv;
    int unsigned cap;
    logic [131:0] wide;
    if (lit_digits == 0 && c == "0") return;
    case (lit_base)
      BASE_HEX: cap = 32;
      BASE_OCT: cap = 43;
      BASE_BIN: cap = 128;
      default:  cap = 39;
    endcase
    // digit limit wins over validity
    if (lit_digits + 1 > cap) begin
      settle(ST_OVERFLOW);
      return;
    end
    dv = digit_of(c, lit_base);
    if (dv < 0) begin
      settle(ST_INVALID);
      return;
    end
    case (lit_base)
      BASE_HEX: lit_acc = {lit_acc[123:0], 4'(dv)};
      BASE_BIN: lit_acc = {lit_acc[126:0], 1'(dv)};
      BASE_OCT: begin
        if (lit_acc[127:125] != 3'd0) begin
          settle(ST_OVERFLOW);
          return;
        end
        lit_acc = {lit_acc[124:0], 3'(dv)};
      end
      default: begin
        wide = 132'(lit_acc) * 132'd10 + 132'(dv);
        if (wide[131:128] != 4'd0) begin
          settle(ST_OVERFLOW);
          return;
        end
        lit_acc = wide[127:0];
      end
    endcase
    lit_digits++;
  endfunction

  // Returns 1 when the character closes a literal; res then holds its parse.
  function automatic bit parse_char(byte unsigned c, bit last, output ulp_result_t res);
    res = '0;
    case (lit_phase)
      PH_START: begin
        if (c == "0" && !last) begin
          lit_phase = PH_ZERO;
        end else begin
          lit_phase = PH_DIGITS;
          lit_base = BASE_DEC;
          push_digit(c);
        end
      end
      PH_ZERO: begin
        if (!last && (c == "x" || c == "X" || c == "o" || c == "b")) begin
          lit_base = (c == "o") ? BASE_OCT : (c == "b") ? BASE_BIN : BASE_HEX;
          lit_phase = PH_DIGITS;
        end else begin
          lit_base = BASE_DEC;
          lit_phase = PH_DIGITS;
          push_digit(c);
        end
      end
      PH_DIGITS: push_digit(c);
      default: ;
    endcase
    if (!last) return 1'b0;
    res.value = lit_acc;
    res.status = lit_status;
    clear_literal();
    return 1'b1;
  endfunction

  function automatic byte unsigned rand_digit(ulp_base_e b);
    int v;
    case (b)
      BASE_HEX: begin
        v = $urandom_range(0, 15);
        if (v < 10) return "0" + v;
        return ($urandom_range(0, 1) ? "a" : "A") + v - 10;
      end
      BASE_OCT: return "0" + $urandom_range(0, 7);
      BASE_BIN: return "0" + $urandom_range(0, 1);
      default:  return "0" + $urandom_range(0, 9);
    endcase
  endfunction

  function automatic void build_random_literal();
    string dec_edge;
    int kind;
    int n;
    int cap;
    ulp_base_e b;
    dec_edge = "34028236692093846346337460743176821145";
    lit_chars.delete();
    kind = $urandom_range(0, 15);
    if (kind == 0) begin
      repeat ($urandom_range(1, 6)) lit_chars.push_back(8'($urandom_range(1, 255)));
      return;
    end
    b = (kind < 7) ? BASE_DEC : (kind < 10) ? BASE_HEX : (kind < 13) ? BASE_OCT : BASE_BIN;
    case (b)
      BASE_HEX: begin
        lit_chars.push_back("0");
        lit_chars.push_back($urandom_range(0, 1) ? "x" : "X");
        cap = 32;
      end
      BASE_OCT: begin
        lit_chars.push_back("0");
        lit_chars.push_back("o");
        cap = 43;
      end
      BASE_BIN: begin
        lit_chars.push_back("0");
        lit_chars.push_back("b");
        cap = 128;
      end
      default: cap = 39;
    endcase
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) lit_chars.push_back("0");
    if ($urandom_range(0, 9) == 0) n = $urandom_range(cap - 2, cap + 1);
    else n = $urandom_range(0, 8);
    if (b == BASE_DEC && n == 39 && $urandom_range(0, 1)) begin
      // sits right at the 2^128 boundary; last digit decides
      for (int i = 0; i < dec_edge.len(); i++) lit_chars.push_back(dec_edge[i]);
      lit_chars.push_back(rand_digit(BASE_DEC));
    end else begin
      repeat (n) lit_chars.push_back(rand_digit(b));
    end
    if (lit_chars.size() == 0) lit_chars.push_back("0");
    if ($urandom_range(0, 7) == 0)
      lit_chars[$urandom_range(0, lit_chars.size() - 1)] = 8'($urandom_range(1, 255));
    if ($urandom_range(0, 15) == 0) lit_chars.push_back(8'($urandom_range(1, 255)));
  endfunction

  task automatic send_byte(input byte unsigned c, input bit last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    char_code_i <= c;
    is_last_i <= last;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_literal(input bit typed, input ulp_result_t fixed);
    ulp_result_t got;
    for (int i = 0; i < lit_chars.size(); i++) begin
      send_byte(lit_chars[i], i == lit_chars.size() - 1);
      if (parse_char(lit_chars[i], i == lit_chars.size() - 1, got))
        parses_due.push_back(typed ? fixed : got);
    end
  endtask

  // Hold the sender off until every pending parse has come out.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (parses_due.size() != 0);
  endtask

  always @(posedge clk_i) begin : result_check
    ulp_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (parses_due.size() == 0) begin
        $display("%0t: result with none pending: %h_%h status %0d", $time,
                 value_high_o, value_low_o, parse_status_o);
        fail_count++;
      end else begin
        want = parses_due.pop_front();
        if (value_high_o !== want.value[127:64]) begin
          $display("%0t: value_high expected %h, got %h", $time, want.value[127:64],
                   value_high_o);
          fail_count++;
        end
        if (value_low_o !== want.value[63:0]) begin
          $display("%0t: value_low expected %h, got %h", $time, want.value[63:0], value_low_o);
          fail_count++;
        end
        if (parse_status_o !== want.status) begin
          $display("%0t: parse_status expected %0d, got %0d", $time, want.status,
                   parse_status_o);
          fail_count++;
        end
      end
    end
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  initial begin
    ulp_result_t fixed;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < NumRows; r++) begin
      lit_chars.delete();
      for (int i = 0; i < lit_table[r].lead.len(); i++) lit_chars.push_back(lit_table[r].lead[i]);
      repeat (lit_table[r].fill_n) lit_chars.push_back(lit_table[r].fill);
      for (int i = 0; i < lit_table[r].tail.len(); i++) lit_chars.push_back(lit_table[r].tail[i]);
      fixed.value = lit_table[r].value;
      fixed.status = lit_table[r].status;
      send_literal(lit_table[r].typed, fixed);
    end

    for (int p = 0; p < 4; p++) begin
      wait_drained();
      send_idle_pct = idle_pcts[p];
      stall_pct = stall_pcts[p];
      while (items_sent < (p + 1) * RandomItems / 4) begin
        build_random_literal();
        items_sent += lit_chars.size();
        send_literal(1'b0, '0);
      end
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
